### design/pcpa_pkg.sv
package pcpa_pkg;

  localparam int unsigned CpuCountDef = 8;
  localparam int unsigned MaxPagesDef = 32768;

  localparam int unsigned AddrW     = 32;
  localparam int unsigned PageShift = 12;
  localparam int unsigned PageNumW  = AddrW - PageShift;
  // A base page number can reach 2^20, so it needs one bit beyond a page number.
  localparam int unsigned BaseW     = PageNumW + 1;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CfgRegionStart = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRegionLimit = CfgIdxW'(1);

  localparam logic [AddrW-1:0] RegionStartRst = 32'h8000_0000;
  localparam logic [AddrW-1:0] RegionLimitRst = 32'h8800_0000;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BADFREE = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             command;
    logic [2:0]       requester;
    logic [AddrW-1:0] page_address;
  } in_word_t;

  typedef struct packed {
    logic [AddrW-1:0] granted_address;
    status_e          status;
  } out_word_t;

endpackage

### design/per_cpu_page_allocator.sv
// Channel  | Direction | Handshake                      | Word
// ---------+-----------+--------------------------------+--------------------------------
// in       | input     | in_valid_i / in_ready_o        | command, requester, page_address
// out      | output    | out_valid_o / out_ready_i      | granted_address, status
// cfg      | input     | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// An allocate steps through base, read and pop (no pop when every list is empty) and a
// free through base, low bound, high bound, index and push, using the shared 32-bit adder
// and the registered read port of the link memory. A new word is accepted while the last
// result waits in the output register; a finished result that finds that register full
// holds off the input. Reset clears the list flags and control state and loads the region
// registers; heads and links need no clearing pass. The config port is always ready.
module per_cpu_page_allocator #(
  parameter int unsigned CPU_COUNT = pcpa_pkg::CpuCountDef,
  parameter int unsigned MAX_PAGES = pcpa_pkg::MaxPagesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pcpa_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pcpa_pkg::out_word_t            out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcpa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pcpa_pkg::AddrW-1:0]     cfg_data_i
);
  import pcpa_pkg::*;

  localparam int unsigned IW      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CW      = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int unsigned ReqExtW = (CW > 3) ? CW : 3;
  localparam logic [BaseW-1:0] MaxPagesW = BaseW'(MAX_PAGES);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_BASE      = 8'b0000_0010,
    S_FREE_LO   = 8'b0000_0100,
    S_FREE_HI   = 8'b0000_1000,
    S_FREE_IDX  = 8'b0001_0000,
    S_FREE_PUSH = 8'b0010_0000,
    S_ALLOC_RD  = 8'b0100_0000,
    S_ALLOC_POP = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic                 resp_q, resp_d;

  in_word_t             in_q;
  logic [AddrW-1:0]     region_start_q, region_limit_q;
  logic [BaseW-1:0]     base_q, diff_q;
  logic                 bad_q;
  logic [CW-1:0]        cur_q;
  logic                 found_q;
  logic [IW-1:0]        idx_q;
  logic [AddrW-1:0]     res_addr_q;
  status_e              res_status_q;
  out_word_t            out_q;
  logic                 out_valid_q;

  logic [IW-1:0]        head_q [CPU_COUNT];
  logic [CPU_COUNT-1:0] nonempty_q;

  logic [IW:0]          link_mem [MAX_PAGES];
  logic [IW:0]          rdata_q;
  logic                 mem_we;
  logic [IW:0]          mem_wdata;

  // Shared adder: sum = a + (sub ? ~b : b) + (sub | cin), carry out in bit 32.
  logic [AddrW-1:0]     alu_a, alu_b;
  logic                 alu_sub, alu_cin;
  logic [AddrW:0]       alu_sum;

  logic                 req_ok;
  logic [ReqExtW-1:0]   req_ext;
  logic [CW-1:0]        low_idx;
  logic                 push_ok;
  logic                 out_load;

  assign in_ready_o  = (state_q == S_IDLE) && !resp_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign req_ok  = 32'(in_q.requester) < CPU_COUNT;
  assign req_ext = ReqExtW'(in_q.requester);

  // Lowest-numbered list that holds a page.
  always_comb begin
    low_idx = '0;
    for (int i = CPU_COUNT - 1; i >= 0; i--) begin
      if (nonempty_q[i]) begin
        low_idx = CW'(i);
      end
    end
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    alu_cin = 1'b0;
    case (state_q)
      S_BASE: begin
        alu_a   = AddrW'(region_start_q[AddrW-1:PageShift]);
        alu_cin = |region_start_q[PageShift-1:0];
      end
      S_FREE_LO: begin
        alu_a   = in_q.page_address;
        alu_b   = region_start_q;
        alu_sub = 1'b1;
      end
      S_FREE_HI: begin
        alu_a   = in_q.page_address;
        alu_b   = region_limit_q;
        alu_sub = 1'b1;
      end
      S_FREE_IDX: begin
        alu_a   = AddrW'(in_q.page_address[AddrW-1:PageShift]);
        alu_b   = AddrW'(base_q);
        alu_sub = 1'b1;
      end
      S_ALLOC_POP: begin
        alu_a = AddrW'(base_q);
        alu_b = AddrW'(idx_q);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + (AddrW + 1)'(alu_sub | alu_cin);

  assign push_ok   = !bad_q && (diff_q < MaxPagesW);
  assign mem_we    = (state_q == S_FREE_PUSH) && push_ok;
  assign mem_wdata = nonempty_q[cur_q] ? {1'b1, head_q[cur_q]} : '0;
  assign out_load  = resp_q && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    if (out_load) begin
      resp_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        state_d = (in_q.command == CMD_FREE) ? S_FREE_LO : S_ALLOC_RD;
      end
      S_FREE_LO:  state_d = S_FREE_HI;
      S_FREE_HI:  state_d = S_FREE_IDX;
      S_FREE_IDX: state_d = S_FREE_PUSH;
      S_FREE_PUSH: begin
        state_d = S_IDLE;
        resp_d  = 1'b1;
      end
      S_ALLOC_RD: begin
        if (found_q) begin
          state_d = S_ALLOC_POP;
        end else begin
          state_d = S_IDLE;
          resp_d  = 1'b1;
        end
      end
      S_ALLOC_POP: begin
        state_d = S_IDLE;
        resp_d  = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      resp_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      nonempty_q     <= '0;
      region_start_q <= RegionStartRst;
      region_limit_q <= RegionLimitRst;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgRegionStart: region_start_q <= cfg_data_i;
          CfgRegionLimit: region_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (mem_we) begin
        nonempty_q[cur_q] <= 1'b1;
      end else if (state_q == S_ALLOC_POP && !rdata_q[IW]) begin
        nonempty_q[cur_q] <= 1'b0;
      end
    end
  end

  // Datapath registers; they carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
    if (out_load) begin
      out_q.granted_address <= res_addr_q;
      out_q.status          <= res_status_q;
    end
    case (state_q)
      S_BASE: begin
        base_q <= alu_sum[BaseW-1:0];
        if (in_q.command == CMD_FREE) begin
          bad_q   <= !req_ok || (in_q.page_address[PageShift-1:0] != '0);
          cur_q   <= req_ext[CW-1:0];
          found_q <= 1'b0;
        end else begin
          bad_q   <= 1'b0;
          found_q <= |nonempty_q;
          cur_q   <= (req_ok && nonempty_q[req_ext[CW-1:0]]) ? req_ext[CW-1:0] : low_idx;
        end
      end
      S_FREE_LO: begin
        if (!alu_sum[AddrW]) begin
          bad_q <= 1'b1;
        end
      end
      S_FREE_HI: begin
        if (alu_sum[AddrW]) begin
          bad_q <= 1'b1;
        end
      end
      S_FREE_IDX: begin
        diff_q <= alu_sum[BaseW-1:0];
      end
      S_FREE_PUSH: begin
        res_addr_q   <= '0;
        res_status_q <= push_ok ? ST_OK : ST_BADFREE;
        if (push_ok) begin
          head_q[cur_q] <= diff_q[IW-1:0];
        end
      end
      S_ALLOC_RD: begin
        idx_q        <= head_q[cur_q];
        res_addr_q   <= '0;
        res_status_q <= ST_OOM;
      end
      S_ALLOC_POP: begin
        res_addr_q   <= {alu_sum[PageNumW-1:0], {PageShift{1'b0}}};
        res_status_q <= ST_OK;
        if (rdata_q[IW]) begin
          head_q[cur_q] <= rdata_q[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Link memory: one write port, one registered read port at the current head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[diff_q[IW-1:0]] <= mem_wdata;
    end
    rdata_q <= link_mem[head_q[cur_q]];
  end

  // A refused or empty result never carries an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != ST_OK) |-> out_word_o.granted_address == '0)
    else $error("non-ok result carries an address");

  // One word at a time: after an acceptance the input side closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a word is in work");

  // A list can only become non-empty through a successful push.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(|nonempty_q) |-> $past(mem_we))
    else $error("list filled without a push");

endmodule

### tb/tb_per_cpu_page_allocator.sv
`timescale 1ns / 100ps

// Testbench for the per-CPU page allocator. Frees and allocations go in through
// the input channel, and each one comes back as exactly one reply word. A
// predictor in this file keeps its own copy of the free lists, the link memory
// and the two region registers. It works out the reply for every word at the
// moment that word is accepted. The monitor then compares each reply, field by
// field, with the oldest prediction.
module tb_per_cpu_page_allocator;
  import pcpa_pkg::*;

  localparam int ClkPeriod  = 10;
  localparam int CpuCount   = CpuCountDef;
  localparam int MaxPages   = MaxPagesDef;
  localparam int HeadW      = $clog2(MaxPages);
  localparam int PhaseItems = 280;
  // The watchdog limit covers the long receiver hold-off with a wide margin.
  localparam int StallLimit = 5000;
  localparam int HoldCycles = 400;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_word_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_word_t           out_word_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgRegionStart;
  logic [AddrW-1:0]    cfg_data_i  = '0;

  per_cpu_page_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Shadow of the allocator state. Registers start at their reset values; the
  // list flags are cleared before reset is released.
  logic [AddrW-1:0] region_start = RegionStartRst;
  logic [AddrW-1:0] region_limit = RegionLimitRst;
  logic [HeadW-1:0] list_head     [CpuCount];
  logic             list_nonempty [CpuCount];
  logic [HeadW:0]   next_link     [MaxPages];

  in_word_t         pending_words[$];
  out_word_t        expected_replies[$];
  // Addresses handed out by allocations, so that later frees return real pages.
  logic [AddrW-1:0] free_pool[$];

  int  mismatches   = 0;
  int  replies_seen = 0;

  logic in_fire, out_fire, cfg_fire;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  // The base page is region_start rounded up to a page boundary. It can reach
  // 2^20, so it is one bit wider than a page number.
  function automatic logic [PageNumW:0] base_page_num();
    logic [AddrW:0] rounded;
    rounded = {1'b0, region_start} + (AddrW + 1)'(12'hFFF);
    return rounded[AddrW:PageShift];
  endfunction

  // Applies one command to the shadow state and returns the reply it causes.
  function automatic out_word_t predict_reply(in_word_t w);
    out_word_t         r;
    logic [PageNumW:0] base;
    logic [PageNumW:0] sum;
    logic [HeadW:0]    link;
    longint            idx;
    int                owner;
    r.granted_address = '0;
    r.status          = ST_OK;
    base              = base_page_num();
    if (w.command == CMD_FREE) begin
      idx = longint'(w.page_address >> PageShift) - longint'(base);
      // A free must be aligned, inside the region and within the link store.
      if (int'(w.requester) >= CpuCount || w.page_address[PageShift-1:0] != '0 ||
          w.page_address < region_start || w.page_address >= region_limit ||
          idx < 0 || idx >= MaxPages) begin
        r.status = ST_BADFREE;
      end else begin
        next_link[idx] = list_nonempty[w.requester] ?
                         {1'b1, list_head[w.requester]} : '0;
        list_head[w.requester]     = idx[HeadW-1:0];
        list_nonempty[w.requester] = 1'b1;
      end
      return r;
    end
    // An allocation takes from its own list first, else steals from the
    // lowest-numbered list that still holds a page.
    owner = -1;
    if (int'(w.requester) < CpuCount && list_nonempty[w.requester]) begin
      owner = w.requester;
    end else begin
      for (int i = 0; i < CpuCount; i++) begin
        if (owner < 0 && list_nonempty[i]) owner = i;
      end
    end
    if (owner < 0) begin
      r.status = ST_OOM;
    end else begin
      sum  = base + (PageNumW + 1)'(list_head[owner]);
      r.granted_address = {sum[PageNumW-1:0], {PageShift{1'b0}}};
      link = next_link[list_head[owner]];
      if (link[HeadW]) begin
        list_head[owner] = link[HeadW-1:0];
      end else begin
        list_nonempty[owner] = 1'b0;
      end
    end
    return r;
  endfunction

  // Driver. Words leave the pending queue in bursts of random length with
  // random gaps between them. Valid holds until the word is taken.
  int burst_left = 0;
  int gap_left   = 0;
  bit offer_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      offer_next = in_valid_i;
      if (in_fire) begin
        out_word_t reply;
        reply = predict_reply(in_word_i);
        expected_replies.push_back(reply);
        if (in_word_i.command == CMD_ALLOC && reply.status == ST_OK) begin
          free_pool.push_back(reply.granted_address);
          if (free_pool.size() > 256) void'(free_pool.pop_front());
        end
        offer_next = 1'b0;
      end
      if (!offer_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          in_word_i <= pending_words.pop_front();
          offer_next = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid_i <= offer_next;
    end
  end

  // Monitor. Checks every reply and drives ready on a pattern of its own: runs
  // of steady ready, of coin flips and of heavy stalling. Once, after a few
  // hundred replies, it holds ready low for a long stretch so that the block
  // fills up and pushes back on its input.
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  int  mode_left  = 0;
  int  stall_mode = 0;
  bit  ready_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_fire) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          mismatches++;
          $error("reply word with nothing expected: granted_address %08h status %0d",
                 out_word_o.granted_address, out_word_o.status);
        end else begin
          out_word_t want;
          want = expected_replies.pop_front();
          if (out_word_o.granted_address !== want.granted_address) begin
            mismatches++;
            $error("granted_address: expected %08h, actual %08h",
                   want.granted_address, out_word_o.granted_address);
          end
          if (out_word_o.status !== want.status) begin
            mismatches++;
            $error("field status expected %0d, actual %0d", want.status, out_word_o.status);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!hold_done && replies_seen >= 500) begin
        hold_done  = 1'b1;
        hold_left  = HoldCycles;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(2);
          mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
          0: ready_next = 1'b1;
          1: ready_next = $urandom_range(1) == 1;
          default: ready_next = $urandom_range(4) == 0;
        endcase
      end
      out_ready_i <= ready_next;
    end
  end

  // Watchdog: any cycle with a handshake on some channel restarts the count.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < StallLimit) begin
      @(posedge clk_i);
      if (in_fire || out_fire || cfg_fire) stuck = 0;
      else stuck++;
    end
    $display("status: fail");
    $finish;
  end

  // Queues one word for the driver, keeping only a few ahead of it so that the
  // pool of granted pages stays current.
  task automatic push_item(cmd_e cmd, logic [2:0] cpu, logic [AddrW-1:0] addr);
    in_word_t w;
    while (pending_words.size() >= 4) @(negedge clk_i);
    w.command      = cmd;
    w.requester    = cpu;
    w.page_address = addr;
    pending_words.push_back(w);
  endtask

  // Returns once every queued word has been taken and every reply has arrived.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_replies.size() != 0);
  endtask

  // Register write through the config channel; only called while idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [AddrW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == CfgRegionStart) region_start = data;
    else if (idx == CfgRegionLimit) region_limit = data;
    cfg_valid_i <= 1'b0;
    // Granted addresses may fall outside a new region, so start over.
    free_pool.delete();
  endtask

  // Random traffic under the current region. Most frees return granted pages
  // or pick pages inside the region; a tenth are malformed. The share of frees
  // changes every 40 words so that lists fill up and run dry in turn.
  task automatic run_random(int count);
    logic [PageNumW:0] base;
    longint            lo, hi, span, off;
    bit                have_range;
    int                free_pct;
    int                pick;
    logic [AddrW-1:0]  addr;
    base       = base_page_num();
    lo         = base;
    hi         = (longint'(region_limit) - 1) >>> PageShift;
    if (hi > lo + MaxPages - 1) hi = lo + MaxPages - 1;
    have_range = region_limit != 0 && base <= 21'hFFFFF && hi >= lo;
    free_pct   = 50;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: free_pct = 15;
          1: free_pct = 50;
          default: free_pct = 85;
        endcase
      end
      addr = $urandom;
      if ($urandom_range(99) < free_pct) begin
        if (!have_range || $urandom_range(9) == 0) begin
          case ($urandom_range(2))
            0: addr = $urandom;
            1: addr = {addr[AddrW-1:PageShift], 12'(1 + $urandom_range(12'hFFE))};
            default: addr = region_limit;
          endcase
        end else if (free_pool.size() > 0 && $urandom_range(9) < 7) begin
          pick = $urandom_range(free_pool.size() - 1);
          addr = free_pool[pick];
          free_pool.delete(pick);
        end else begin
          span = hi - lo;
          off  = ($urandom_range(3) == 0) ? $urandom_range(span) :
                 $urandom_range(span < 63 ? span : 63);
          addr = AddrW'((lo + off) << PageShift);
        end
        push_item(CMD_FREE, 3'($urandom_range(7)), addr);
      end else begin
        push_item(CMD_ALLOC, 3'($urandom_range(7)), addr);
      end
    end
  endtask

  initial begin : stimulus
    logic [AddrW-1:0] rand_start;
    logic [AddrW:0]   rand_end;
    for (int i = 0; i < CpuCount; i++) list_nonempty[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset region 0x8000_0000 .. 0x8800_0000.
    push_item(CMD_ALLOC, 3'd0, 32'h0000_0000);   // every list empty
    push_item(CMD_FREE,  3'd2, 32'h8000_0001);   // not page aligned
    push_item(CMD_FREE,  3'd2, 32'h7FFF_F000);   // below the region
    push_item(CMD_FREE,  3'd2, 32'h8800_0000);   // at the limit
    push_item(CMD_FREE,  3'd2, 32'h0000_0000);
    push_item(CMD_FREE,  3'd3, 32'h8000_0000);   // first page
    push_item(CMD_FREE,  3'd3, 32'h87FF_F000);   // last page the store can hold
    push_item(CMD_FREE,  3'd5, 32'h8000_1000);
    push_item(CMD_FREE,  3'd7, 32'hFFFF_F000);
    push_item(CMD_ALLOC, 3'd3, 32'hFFFF_FFFF);   // pops its own list
    push_item(CMD_ALLOC, 3'd6, 32'h0000_0000);   // steals from CPU 3
    push_item(CMD_ALLOC, 3'd6, 32'h0000_0000);   // steals from CPU 5
    push_item(CMD_ALLOC, 3'd7, 32'h0000_0000);   // out of memory again
    push_item(CMD_FREE,  3'd7, 32'h8000_2000);
    push_item(CMD_ALLOC, 3'd7, 32'hFFFF_FFFF);
    push_item(CMD_FREE,  3'd0, 32'h8000_3000);
    push_item(CMD_FREE,  3'd1, 32'h8000_4000);
    wait_drained();

    // Moving the base while pages sit on the lists: addresses are rebuilt from
    // the new base, which here wraps past the top of the address space.
    write_reg(CfgRegionStart, 32'hFFFF_FFFF);
    push_item(CMD_ALLOC, 3'd1, 32'h0000_0000);
    push_item(CMD_FREE,  3'd0, 32'hFFFF_F000);   // below an unaligned start
    wait_drained();

    write_reg(CfgRegionStart, 32'h0000_0000);
    write_reg(CfgRegionLimit, 32'hFFFF_FFFF);
    push_item(CMD_ALLOC, 3'd0, 32'h0000_0000);
    push_item(CMD_FREE,  3'd4, 32'h0800_0000);   // beyond the store capacity
    push_item(CMD_FREE,  3'd4, 32'h07FF_F000);
    push_item(CMD_FREE,  3'd4, 32'hFFFF_F000);
    push_item(CMD_ALLOC, 3'd4, 32'h0000_0000);
    wait_drained();

    write_reg(CfgRegionLimit, 32'h0000_0000);
    push_item(CMD_FREE, 3'd0, 32'h0000_0000);    // empty region
    wait_drained();

    // An unaligned start rounds the base up by one page.
    write_reg(CfgRegionStart, 32'h0000_0001);
    write_reg(CfgRegionLimit, 32'h0000_3000);
    push_item(CMD_FREE,  3'd2, 32'h0000_1000);
    push_item(CMD_ALLOC, 3'd2, 32'h0000_0000);
    wait_drained();

    // Random phases, each under its own region. Lists are not emptied between
    // phases, so pages freed under one base come back under the next.
    write_reg(CfgRegionStart, RegionStartRst);
    write_reg(CfgRegionLimit, RegionLimitRst);
    run_random(PhaseItems);
    wait_drained();

    write_reg(CfgRegionStart, 32'h0000_0000);
    write_reg(CfgRegionLimit, 32'hFFFF_FFFF);
    run_random(PhaseItems);
    wait_drained();

    write_reg(CfgRegionStart, 32'h0000_0123);
    write_reg(CfgRegionLimit, 32'h0004_0000);
    run_random(PhaseItems);
    wait_drained();

    write_reg(CfgRegionStart, 32'hFFFF_0000);
    write_reg(CfgRegionLimit, 32'hFFFF_FFFF);
    run_random(PhaseItems);
    wait_drained();

    write_reg(CfgRegionStart, 32'h1000_0000);
    write_reg(CfgRegionLimit, 32'h1000_8000);
    run_random(PhaseItems);
    wait_drained();

    for (int p = 0; p < 2; p++) begin
      rand_start = $urandom;
      if ($urandom_range(1) == 0) rand_start[PageShift-1:0] = '0;
      rand_end   = {1'b0, rand_start} + (AddrW + 1)'($urandom_range(32'h1000, 32'h0800_0000));
      write_reg(CfgRegionStart, rand_start);
      write_reg(CfgRegionLimit, rand_end[AddrW] ? 32'hFFFF_FFFF : rand_end[AddrW-1:0]);
      run_random(PhaseItems);
      wait_drained();
    end

    // A short tail catches any stray reply after the last expected one.
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
